// ----- sv/gcq_pkg.sv -----
// Package with widths, register codes, the pipeline item type and helpers of the grid quantizer.
package gcq_pkg;

  localparam int AXES        = 3;
  localparam int CNT_W       = 10;
  localparam int NCNT_W      = 11;
  localparam int COORD_W     = 32;
  localparam int PITCH_W     = 31;
  localparam int LIN_W       = 30;
  localparam int QNUM_W      = 35;
  localparam int QDEN_W      = 32;
  localparam int QBITS       = 11;
  localparam int QCMP_W      = QNUM_W + QBITS;
  localparam int DQ1_W       = 20;
  localparam int DQ2_W       = 10;
  localparam int DIV_STAGES  = DQ1_W + DQ2_W;
  localparam int NXNY_W      = 21;
  localparam int TOTAL_W     = 31;
  localparam int T_W         = 20;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 160;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  localparam logic [NCNT_W-1:0]  MAX_CELLS     = NCNT_W'(1024);
  localparam logic [PITCH_W-1:0] PITCH_RESET   = PITCH_W'(65536);
  localparam logic [LIN_W-1:0]   COUNTS_RESET  = LIN_W'(1049601);

  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_X_PITCH  = 3'd1;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd2;
  localparam logic [2:0] REG_Y_PITCH  = 3'd3;
  localparam logic [2:0] REG_Z_ORIGIN = 3'd4;
  localparam logic [2:0] REG_Z_PITCH  = 3'd5;
  localparam logic [2:0] REG_COUNTS   = 3'd6;

  typedef struct packed {
    logic                          cmd;
    logic                          clip;
    logic [AXES-1:0]               qneg;
    logic [AXES-1:0]               qovf;
    logic [AXES-1:0][QNUM_W-1:0]   qrem;
    logic [AXES-1:0][QBITS-1:0]    qquo;
    logic [LIN_W-1:0]              drem;
    logic [DQ1_W-1:0]              dquo;
    logic [DQ2_W-1:0]              dquo2;
    logic [LIN_W-1:0]              lin;
  } gcq_item_t;

  // A zero count field selects the largest grid.
  function automatic logic [NCNT_W-1:0] axis_count(input logic [CNT_W-1:0] f);
    axis_count = (f == '0) ? MAX_CELLS : {1'b0, f};
  endfunction

  // A zero pitch behaves as the smallest step.
  function automatic logic [PITCH_W-1:0] eff_pitch(input logic [PITCH_W-1:0] p);
    eff_pitch = (p == '0) ? PITCH_W'(1) : p;
  endfunction

endpackage

// ----- sv/grid_cell_quantizer_3d.sv -----
// Top level of the three-axis grid quantizer and linear index decoder.
//
// Items enter on the in_ stream: in_tuser is the command (0 quantizes the point
// in in_tdata, 1 decodes the linear index in in_tdata). Results leave on the
// out_ stream with the axis indices, linear index and snapped coordinates in
// out_tdata and the clamped flag in out_tuser, one result per item, in order.
// The user must set the grid over the cfg_ APB port only while no item is in
// flight; the block does not enforce it. The pipeline has three setup stages,
// thirty one-bit restoring divider stages (twenty for the split by the x count,
// ten for the split by the y count, the quantize quotients sharing the first
// eleven) and three stages for selection, products and output. Throughput is
// one item per cycle while the receiver does not stall; the whole pipeline
// advances together. When the receiver stalls with a result waiting, in_tready
// drops in the same cycle and every stage holds, so nothing is lost or repeated.
// Reset empties the pipeline and loads the register defaults: origins zero,
// pitches 65536, counts of one by one by one cell.
module grid_cell_quantizer_3d (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // point_x, point_y, point_z, linear_in
  input  logic [gcq_pkg::IN_TDATA_W-1:0]        in_tdata,
  // cmd
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // cell_x, cell_y, cell_z, linear_out, snap_x, snap_y, snap_z
  output logic [gcq_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // clamped
  output logic                                  out_tuser,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [gcq_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [gcq_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [gcq_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);
  import gcq_pkg::*;

  logic [AXES-1:0][COORD_W-1:0] origin_r;
  logic [AXES-1:0][PITCH_W-1:0] pitch_r;
  logic [LIN_W-1:0]             counts_r;

  logic [AXES-1:0][PITCH_W-1:0] peff;
  logic [AXES-1:0][QDEN_W-1:0]  den;
  logic [AXES-1:0][NCNT_W-1:0]  ncnt;
  logic                         cfg_wr;
  logic [2:0]                   cfg_idx;

  logic                         adv;

  logic                         p0_vld_r, p1_vld_r, p2_vld_r;
  gcq_item_t                    p0_nxt, p0_r, p1_r, p2_nxt, p2_r;
  logic [NXNY_W-1:0]            nxny_nxt, nxny_r;
  logic [TOTAL_W-1:0]           total_r;

  logic                         div_vld;
  gcq_item_t                    div_item;

  logic                         f0_vld_r, f0_cmd_r, f0_clip_r;
  logic [AXES-1:0][CNT_W-1:0]   f0_idx_nxt, f0_idx_r;
  logic                         f0_clip_nxt;
  logic [LIN_W-1:0]             f0_lin_r;

  logic                         f1_vld_r, f1_cmd_r, f1_clip_r;
  logic [AXES-1:0][CNT_W-1:0]   f1_idx_r;
  logic [AXES-1:0][COORD_W-1:0] f1_snap_nxt, f1_snap_r;
  logic [T_W-1:0]               f1_t_nxt, f1_t_r;
  logic [LIN_W-1:0]             f1_lin_r;

  logic                         out_vld_r;
  logic [OUT_TDATA_W-1:0]       out_data_nxt, out_data_r;
  logic                         out_user_r;
  logic [LIN_W-1:0]             out_lin;

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    assign peff[a] = eff_pitch(pitch_r[a]);
    assign den[a]  = {peff[a], 1'b0};
    assign ncnt[a] = axis_count(counts_r[a*CNT_W +: CNT_W]);
  end

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      pitch_r  <= {AXES{PITCH_RESET}};
      counts_r <= COUNTS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_X_ORIGIN: origin_r[0] <= cfg_pwdata;
        REG_X_PITCH:  pitch_r[0]  <= cfg_pwdata[PITCH_W-1:0];
        REG_Y_ORIGIN: origin_r[1] <= cfg_pwdata;
        REG_Y_PITCH:  pitch_r[1]  <= cfg_pwdata[PITCH_W-1:0];
        REG_Z_ORIGIN: origin_r[2] <= cfg_pwdata;
        REG_Z_PITCH:  pitch_r[2]  <= cfg_pwdata[PITCH_W-1:0];
        REG_COUNTS:   counts_r    <= cfg_pwdata[LIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_X_ORIGIN: cfg_prdata = origin_r[0];
      REG_X_PITCH:  cfg_prdata = {1'b0, pitch_r[0]};
      REG_Y_ORIGIN: cfg_prdata = origin_r[1];
      REG_Y_PITCH:  cfg_prdata = {1'b0, pitch_r[1]};
      REG_Z_ORIGIN: cfg_prdata = origin_r[2];
      REG_Z_PITCH:  cfg_prdata = {1'b0, pitch_r[2]};
      REG_COUNTS:   cfg_prdata = {2'b0, counts_r};
      default:      cfg_prdata = '0;
    endcase
  end

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // Stage P0: offsets, rounded numerators and range checks; x by y count product.
  always_comb begin
    logic [COORD_W-1:0] pt;
    logic [COORD_W:0]   d;
    logic [COORD_W:0]   mag;
    logic [QNUM_W-1:0]  num;
    p0_nxt     = '0;
    p0_nxt.cmd = in_tuser;
    p0_nxt.lin = in_tdata[3*COORD_W +: LIN_W];
    for (int a = 0; a < AXES; a++) begin
      pt  = in_tdata[a*COORD_W +: COORD_W];
      d   = {pt[COORD_W-1], pt} - {origin_r[a][COORD_W-1], origin_r[a]};
      mag = d[COORD_W] ? (~d + 1'b1) : d;
      num = {1'b0, mag, 1'b0} + {{(QNUM_W - PITCH_W){1'b0}}, peff[a]};
      p0_nxt.qrem[a] = num;
      p0_nxt.qneg[a] = d[COORD_W];
      p0_nxt.qovf[a] = {{QBITS{1'b0}}, num} >=
                       {{(QCMP_W - QDEN_W - QBITS){1'b0}}, den[a], {QBITS{1'b0}}};
      if (d[COORD_W] && ({mag, 1'b0} >= {3'b0, peff[a]})) begin
        p0_nxt.clip = 1'b1;
      end
    end
    nxny_nxt = NXNY_W'(ncnt[0]) * NXNY_W'(ncnt[1]);
  end

  // Stage P2: saturate a decode index to the grid size.
  always_comb begin
    logic sat;
    sat    = {1'b0, p1_r.lin} >= total_r;
    p2_nxt = p1_r;
    if (p1_r.cmd) begin
      p2_nxt.clip = sat;
      if (sat) begin
        p2_nxt.lin = total_r[LIN_W-1:0] - 1'b1;
      end
    end
    p2_nxt.drem = p2_nxt.lin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p0_vld_r <= in_tvalid;
      p1_vld_r <= p0_vld_r;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r    <= p0_nxt;
      nxny_r  <= nxny_nxt;
      p1_r    <= p0_r;
      total_r <= TOTAL_W'(nxny_r) * TOTAL_W'(ncnt[2]);
      p2_r    <= p2_nxt;
    end
  end

  gcq_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (p2_vld_r),
    .in_item  (p2_r),
    .nx       (ncnt[0]),
    .ny       (ncnt[1]),
    .den      (den),
    .out_vld  (div_vld),
    .out_item (div_item)
  );

  // Stage F0: pick and clamp the axis indices.
  always_comb begin
    logic [NCNT_W-1:0] nm1;
    f0_clip_nxt = div_item.clip;
    for (int a = 0; a < AXES; a++) begin
      nm1 = ncnt[a] - 1'b1;
      if (div_item.qneg[a]) begin
        f0_idx_nxt[a] = '0;
      end else if (div_item.qovf[a] || (div_item.qquo[a] > nm1)) begin
        f0_idx_nxt[a] = nm1[CNT_W-1:0];
        f0_clip_nxt   = 1'b1;
      end else begin
        f0_idx_nxt[a] = div_item.qquo[a][CNT_W-1:0];
      end
    end
    if (div_item.cmd) begin
      f0_clip_nxt   = div_item.clip;
      f0_idx_nxt[0] = div_item.drem[CNT_W-1:0];
      f0_idx_nxt[1] = div_item.dquo[CNT_W-1:0];
      f0_idx_nxt[2] = div_item.dquo2;
    end
  end

  // Stage F1: snapped coordinates and the inner term of the linear index.
  always_comb begin
    logic [PITCH_W+CNT_W-1:0] prod;
    for (int a = 0; a < AXES; a++) begin
      prod           = peff[a] * f0_idx_r[a];
      f1_snap_nxt[a] = origin_r[a] + prod[COORD_W-1:0];
    end
    f1_t_nxt = T_W'({{(T_W - CNT_W){1'b0}}, f0_idx_r[1]} + ncnt[1] * f0_idx_r[2]);
  end

  // Output stage: the quantize linear index.
  always_comb begin
    logic [LIN_W:0] prod;
    prod    = ncnt[0] * f1_t_r;
    out_lin = f1_cmd_r ? f1_lin_r :
              (LIN_W'({{(LIN_W - CNT_W){1'b0}}, f1_idx_r[0]}) + prod[LIN_W-1:0]);
    out_data_nxt = {4'b0, f1_snap_r[2], f1_snap_r[1], f1_snap_r[0], out_lin,
                    f1_idx_r[2], f1_idx_r[1], f1_idx_r[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r  <= 1'b0;
      f1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      f0_vld_r  <= div_vld;
      f1_vld_r  <= f0_vld_r;
      out_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_cmd_r   <= div_item.cmd;
      f0_clip_r  <= f0_clip_nxt;
      f0_idx_r   <= f0_idx_nxt;
      f0_lin_r   <= div_item.lin;
      f1_cmd_r   <= f0_cmd_r;
      f1_clip_r  <= f0_clip_r;
      f1_idx_r   <= f0_idx_r;
      f1_lin_r   <= f0_lin_r;
      f1_snap_r  <= f1_snap_nxt;
      f1_t_r     <= f1_t_nxt;
      out_data_r <= out_data_nxt;
      out_user_r <= f1_clip_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(p0_vld_r) && $stable(p2_vld_r) && $stable(f0_vld_r) && $stable(f1_vld_r))
    else $error("pipeline moved during a stall");

  a_tail_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && f1_vld_r |=> out_tvalid)
    else $error("item lost before the output register");

  a_div_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && div_vld |=> f0_vld_r)
    else $error("item lost after the divider");

endmodule

// ----- sv/gcq_div_pipe.sv -----
// Bit-per-stage restoring divider pipeline for quantize quotients and linear index splitting.
module gcq_div_pipe (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              adv,
  input  logic                                              in_vld,
  input  gcq_pkg::gcq_item_t                                in_item,
  input  logic [gcq_pkg::NCNT_W-1:0]                        nx,
  input  logic [gcq_pkg::NCNT_W-1:0]                        ny,
  input  logic [gcq_pkg::AXES-1:0][gcq_pkg::QDEN_W-1:0]     den,
  output logic                                              out_vld,
  output gcq_pkg::gcq_item_t                                out_item
);
  import gcq_pkg::*;

  logic [DIV_STAGES-1:0] vld_r;
  gcq_item_t             item_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    gcq_item_t src;
    gcq_item_t s1;
    gcq_item_t s2;

    if (k == 0) begin : g_first
      assign src = in_item;
    end else begin : g_next
      assign src = item_r[k-1];
    end

    // The first DQ1_W stages divide the index by nx, the rest divide that quotient by ny.
    if (k < DQ1_W) begin : g_d1
      localparam int B = DQ1_W - 1 - k;
      always_comb begin
        logic [LIN_W:0] dv;
        dv = {{(LIN_W + 1 - NCNT_W){1'b0}}, nx} << B;
        s1 = src;
        if ({1'b0, src.drem} >= dv) begin
          s1.drem    = src.drem - dv[LIN_W-1:0];
          s1.dquo[B] = 1'b1;
        end
      end
    end else begin : g_d2
      localparam int B = DIV_STAGES - 1 - k;
      always_comb begin
        logic [DQ1_W:0] dv;
        dv = {{(DQ1_W + 1 - NCNT_W){1'b0}}, ny} << B;
        s1 = src;
        if ({1'b0, src.dquo} >= dv) begin
          s1.dquo     = src.dquo - dv[DQ1_W-1:0];
          s1.dquo2[B] = 1'b1;
        end
      end
    end

    if (k < QBITS) begin : g_q
      localparam int B = QBITS - 1 - k;
      always_comb begin
        logic [QCMP_W-1:0] dv;
        s2 = s1;
        for (int a = 0; a < AXES; a++) begin
          dv = {{(QCMP_W - QDEN_W){1'b0}}, den[a]} << B;
          if ({{QBITS{1'b0}}, s1.qrem[a]} >= dv) begin
            s2.qrem[a]    = s1.qrem[a] - dv[QNUM_W-1:0];
            s2.qquo[a][B] = 1'b1;
          end
        end
      end
    end else begin : g_nq
      assign s2 = s1;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        item_r[k] <= s2;
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_item = item_r[DIV_STAGES-1];

endmodule
